// ===== rtl/core/dda_column_raycaster_macros.svh =====
// Assertion helpers shared by the raycaster RTL.
`ifndef DDA_COLUMN_RAYCASTER_MACROS_SVH
`define DDA_COLUMN_RAYCASTER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define DCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define DCR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dcr_pkg.sv =====
package dcr_pkg;

    localparam int DIV_W  = 42;
    localparam int DEN_W  = 32;
    localparam int CNT_W  = 6;
    localparam int RAY_W  = 32;
    localparam int SIDE_W = 42;
    localparam int DIST_W = 31;
    localparam int LH_W   = 16;

    localparam logic [DIST_W-1:0] DIST_SAT = 31'h7FFF_FFFF;
    localparam logic [LH_W-1:0]   LINE_SAT = 16'hFFFF;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] iters;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== rtl/core/dcr_div.sv =====
module dcr_div
    import dcr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // The numerator arrives aligned to the top of the word; one quotient bit per cycle.
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.go)
        begin
            cnt_next = req.iters;
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== rtl/core/dcr_map.sv =====
module dcr_map
    import dcr_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dda_column_raycaster.sv =====
// DDA column raycaster.
// A request is taken at a rising edge with start high and busy low. With kind 0
// it writes cell_value into the map cell (cell_x, cell_y) in that same cycle and
// gives no result; a cell outside the map is left alone. With kind 1 it casts
// the ray for the given screen column; busy stays high until the cast is done,
// and the result is shown for one cycle with done high, the cycle busy falls.
// The receiver cannot stall, so nothing waits on the result side.
// A cast walks at most 2*MAP_SIZE+2 grid cells and skips a division when a ray
// component or the distance is zero. The shared divider produces one quotient bit
// per cycle over five divisions (camera factor, two deltas, distance, line height);
// the shared 32x32 multiplier registers its product.
// Camera registers are written through cfg_we, cfg_index and cfg_data, one per cycle;
// the user must write them only while no cast is in flight; the block does not check.
// Reset returns them to their default view and leaves map contents undefined until written.
`include "dda_column_raycaster_macros.svh"

module dda_column_raycaster
    import dcr_pkg::*;
#(
    parameter int SCREEN_W = 640,
    parameter int SCREEN_H = 480,
    parameter int MAP_SIZE = 64,
    parameter int TEX_W    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [7:0]  cell_value,
    input  logic [9:0]  column,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_data,
    output logic        done,
    output logic [9:0]  out_column,
    output logic [30:0] wall_distance,
    output logic [15:0] line_height,
    output logic [8:0]  wall_row_start,
    output logic [8:0]  wall_row_end,
    output logic        hit_side,
    output logic [1:0]  texture_index,
    output logic [5:0]  texture_column,
    output logic [5:0]  hit_x,
    output logic [5:0]  hit_y,
    output logic        no_wall
);

    localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int STEP_MAX  = 2 * MAP_SIZE + 2;
    localparam int STEP_W    = $clog2(STEP_MAX + 1);
    localparam int CELL_W    = 10;

    localparam logic [DEN_W-1:0]  SCREEN_W_DEN = DEN_W'(SCREEN_W);
    localparam logic [DIV_W-1:0]  HGT_NUM      = DIV_W'(SCREEN_H) << 29;
    localparam logic [DIV_W-1:0]  DELTA_NUM    = DIV_W'(1) << 41;
    localparam logic [8:0]        MAP_LIM      = 9'(MAP_SIZE);
    localparam logic [MAP_AW-1:0] MAP_ROW      = MAP_AW'(MAP_SIZE);
    localparam logic [16:0]       SH17         = 17'(SCREEN_H);
    localparam logic [15:0]       ROW_LAST     = 16'(SCREEN_H - 1);
    localparam logic [25:0]       TEX_MUL      = 26'(TEX_W);
    localparam logic [STEP_W-1:0] STEP_LAST    = STEP_W'(STEP_MAX);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CAMX  = 4'd1;
    localparam logic [3:0] S_RAY   = 4'd2;
    localparam logic [3:0] S_DELTA = 4'd3;
    localparam logic [3:0] S_SIDE  = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_FETCH = 4'd6;
    localparam logic [3:0] S_TEST  = 4'd7;
    localparam logic [3:0] S_DIST  = 4'd8;
    localparam logic [3:0] S_HGT   = 4'd9;
    localparam logic [3:0] S_WALL  = 4'd10;

    logic [22:0] pos_x_reg, pos_y_reg;
    logic [18:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    logic [3:0]               state_reg, state_next;
    logic                     ax_reg, ax_next;
    logic                     ph_reg, ph_next;
    logic                     done_reg, done_next;
    logic [9:0]               col_reg, col_next;
    logic signed [27:0]       camx_reg, camx_next;
    logic signed [RAY_W-1:0]  ray_x_reg, ray_x_next, ray_y_reg, ray_y_next;
    logic [DIST_W-1:0]        delta_x_reg, delta_x_next, delta_y_reg, delta_y_next;
    logic [SIDE_W-1:0]        side_x_reg, side_x_next, side_y_reg, side_y_next;
    logic signed [CELL_W-1:0] walk_x_reg, walk_x_next, walk_y_reg, walk_y_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic                     hit_i_reg, hit_i_next;
    logic [DIST_W-1:0]        dist_reg, dist_next;
    logic [LH_W-1:0]          lh_reg, lh_next;

    logic [9:0]  res_column_reg, res_column_next;
    logic [30:0] res_dist_reg, res_dist_next;
    logic [15:0] res_lh_reg, res_lh_next;
    logic [8:0]  res_start_reg, res_start_next;
    logic [8:0]  res_end_reg, res_end_next;
    logic        res_side_reg, res_side_next;
    logic [1:0]  res_tex_reg, res_tex_next;
    logic [5:0]  res_texcol_reg, res_texcol_next;
    logic [5:0]  res_hx_reg, res_hx_next;
    logic [5:0]  res_hy_reg, res_hy_next;
    logic        res_nowall_reg, res_nowall_next;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic              map_we;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic [7:0]        map_rdata;

    logic signed [RAY_W-1:0] ray_ax, ray_h, ray_o;
    logic [DEN_W-1:0]        ray_mag_ax, ray_mag_h;
    logic [22:0]             pos_ax, pos_h, pos_o;
    logic [18:0]             dir_ax, plane_ax;
    logic [DIST_W-1:0]       delta_ax, delta_sat;
    logic [16:0]             frac_f;
    logic                    go_x;
    logic                    off_map;
    logic                    accept;
    logic signed [26:0]      num_v;
    logic [26:0]             num_mag;
    logic [15:0]             wall_lo;
    logic [25:0]             tex_prod;
    logic [16:0]             row_sum, row_diff;
    logic [15:0]             row_half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= 23'd98304;
            pos_y_reg   <= 23'd98304;
            dir_x_reg   <= 19'd65536;
            dir_y_reg   <= 19'd0;
            plane_x_reg <= 19'd0;
            plane_y_reg <= 19'd43254;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_data;
                REG_POS_Y:   pos_y_reg   <= cfg_data;
                REG_DIR_X:   dir_x_reg   <= cfg_data[18:0];
                REG_DIR_Y:   dir_y_reg   <= cfg_data[18:0];
                REG_PLANE_X: plane_x_reg <= cfg_data[18:0];
                REG_PLANE_Y: plane_y_reg <= cfg_data[18:0];
                default:     ;
            endcase
        end
    end

    assign accept    = start && (state_reg == S_IDLE);
    assign map_we    = accept && !kind && ({3'b0, cell_x} < MAP_LIM) && ({3'b0, cell_y} < MAP_LIM);
    assign map_waddr = MAP_AW'(cell_y) * MAP_ROW + MAP_AW'(cell_x);
    assign map_raddr = MAP_AW'(walk_y_reg[8:0]) * MAP_ROW + MAP_AW'(walk_x_reg[8:0]);

    dcr_map #(
        .DEPTH (MAP_DEPTH),
        .AW    (MAP_AW)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (cell_value),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    dcr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        ray_ax     = ax_reg ? ray_y_reg : ray_x_reg;
        pos_ax     = ax_reg ? pos_y_reg : pos_x_reg;
        dir_ax     = ax_reg ? dir_y_reg : dir_x_reg;
        plane_ax   = ax_reg ? plane_y_reg : plane_x_reg;
        delta_ax   = ax_reg ? delta_y_reg : delta_x_reg;
        ray_mag_ax = ray_ax[RAY_W-1] ? DEN_W'(-ray_ax) : DEN_W'(ray_ax);
        ray_h      = hit_i_reg ? ray_y_reg : ray_x_reg;
        ray_o      = hit_i_reg ? ray_x_reg : ray_y_reg;
        pos_h      = hit_i_reg ? pos_y_reg : pos_x_reg;
        pos_o      = hit_i_reg ? pos_x_reg : pos_y_reg;
        ray_mag_h  = ray_h[RAY_W-1] ? DEN_W'(-ray_h) : DEN_W'(ray_h);
        delta_sat  = (div_rsp.quo > DIV_W'(DIST_SAT)) ? DIST_SAT : div_rsp.quo[DIST_W-1:0];
        frac_f     = ray_ax[RAY_W-1] ? {1'b0, pos_ax[15:0]} : 17'h10000 - {1'b0, pos_ax[15:0]};
        go_x       = (side_x_reg < side_y_reg);
        off_map    = walk_x_reg[CELL_W-1] || (walk_x_reg[8:0] >= MAP_LIM)
                  || walk_y_reg[CELL_W-1] || (walk_y_reg[8:0] >= MAP_LIM);
        num_v      = $signed({2'b0, (hit_i_reg ? walk_y_reg[8:0] : walk_x_reg[8:0]), 16'b0})
                   - $signed({4'b0, pos_h})
                   + $signed({10'b0, ray_h[RAY_W-1], 16'b0});
        num_mag    = num_v[26] ? 27'(-num_v) : 27'(num_v);
        wall_lo    = pos_o[15:0] + prod_reg[31:16];
        tex_prod   = 26'(wall_lo) * TEX_MUL;
        row_sum    = SH17 + {1'b0, lh_reg};
        row_diff   = SH17 - {1'b0, lh_reg};
        row_half   = row_sum[16:1];
    end

    always_comb
    begin
        mul_a = {{13{plane_ax[18]}}, plane_ax};
        mul_b = {{4{camx_reg[27]}}, camx_reg};
        case (state_reg)
            S_SIDE:
            begin
                mul_a = {15'b0, frac_f};
                mul_b = {1'b0, delta_ax};
            end
            S_WALL:
            begin
                mul_a = {1'b0, dist_reg};
                mul_b = ray_o;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        div_req.go    = 1'b0;
        div_req.iters = CNT_W'(27);
        div_req.num   = {col_next, 32'b0};
        div_req.den   = SCREEN_W_DEN;
        case (state_reg)
            S_IDLE:
            begin
                div_req.go = accept && kind;
                div_req.num = {column, 32'b0};
            end
            S_DELTA:
            begin
                div_req.go    = !ph_reg && (ray_ax != '0);
                div_req.iters = CNT_W'(33);
                div_req.num   = DELTA_NUM;
                div_req.den   = ray_mag_ax;
            end
            S_DIST:
            begin
                div_req.go    = !ph_reg && (ray_h != '0);
                div_req.iters = CNT_W'(42);
                div_req.num   = {num_mag[25:0], 16'b0};
                div_req.den   = ray_mag_h;
            end
            S_HGT:
            begin
                div_req.go    = !ph_reg && (dist_reg != '0);
                div_req.iters = CNT_W'(29);
                div_req.num   = HGT_NUM;
                div_req.den   = {1'b0, dist_reg};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        ax_next         = ax_reg;
        ph_next         = ph_reg;
        done_next       = 1'b0;
        col_next        = col_reg;
        camx_next       = camx_reg;
        ray_x_next      = ray_x_reg;
        ray_y_next      = ray_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        side_x_next     = side_x_reg;
        side_y_next     = side_y_reg;
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        cnt_next        = cnt_reg;
        hit_i_next      = hit_i_reg;
        dist_next       = dist_reg;
        lh_next         = lh_reg;
        res_column_next = res_column_reg;
        res_dist_next   = res_dist_reg;
        res_lh_next     = res_lh_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        res_side_next   = res_side_reg;
        res_tex_next    = res_tex_reg;
        res_texcol_next = res_texcol_reg;
        res_hx_next     = res_hx_reg;
        res_hy_next     = res_hy_reg;
        res_nowall_next = res_nowall_reg;

        if ((state_reg == S_STEP) || ((state_reg == S_TEST) && (map_rdata == '0)
            && (cnt_reg != STEP_LAST)))
        begin
            cnt_next = cnt_reg + 1'b1;
            if (go_x)
            begin
                side_x_next = side_x_reg + SIDE_W'(delta_x_reg);
                walk_x_next = walk_x_reg + (ray_x_reg[RAY_W-1] ? -10'sd1 : 10'sd1);
                hit_i_next  = 1'b0;
            end
            else
            begin
                side_y_next = side_y_reg + SIDE_W'(delta_y_reg);
                walk_y_next = walk_y_reg + (ray_y_reg[RAY_W-1] ? -10'sd1 : 10'sd1);
                hit_i_next  = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && kind)
                begin
                    col_next   = column;
                    state_next = S_CAMX;
                end
            end
            S_CAMX:
            begin
                if (div_rsp.done)
                begin
                    camx_next  = $signed({1'b0, div_rsp.quo[26:0]}) - 28'sd65536;
                    ax_next    = 1'b0;
                    ph_next    = 1'b0;
                    state_next = S_RAY;
                end
            end
            S_RAY:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (ax_reg)
                    begin
                        ray_y_next = $signed({{13{dir_ax[18]}}, dir_ax}) + prod_reg[47:16];
                        state_next = S_DELTA;
                    end
                    else
                    begin
                        ray_x_next = $signed({{13{dir_ax[18]}}, dir_ax}) + prod_reg[47:16];
                    end
                    ax_next = !ax_reg;
                end
            end
            S_DELTA:
            begin
                if (!ph_reg && (ray_ax == '0))
                begin
                    if (ax_reg) delta_y_next = DIST_SAT;
                    else        delta_x_next = DIST_SAT;
                    ax_next = !ax_reg;
                    if (ax_reg) state_next = S_SIDE;
                end
                else if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    if (ax_reg) delta_y_next = delta_sat;
                    else        delta_x_next = delta_sat;
                    ph_next = 1'b0;
                    ax_next = !ax_reg;
                    if (ax_reg) state_next = S_SIDE;
                end
            end
            S_SIDE:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (ax_reg)
                    begin
                        side_y_next = SIDE_W'(prod_reg[47:16]);
                        walk_y_next = $signed({3'b0, pos_ax[22:16]});
                        cnt_next    = '0;
                        state_next  = S_STEP;
                    end
                    else
                    begin
                        side_x_next = SIDE_W'(prod_reg[47:16]);
                        walk_x_next = $signed({3'b0, pos_ax[22:16]});
                    end
                    ax_next = !ax_reg;
                end
            end
            S_STEP:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_TEST;
                if (off_map)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TEST:
            begin
                state_next = S_FETCH;
                if (map_rdata != '0)
                begin
                    ph_next    = 1'b0;
                    state_next = S_DIST;
                end
                else if (cnt_reg == STEP_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIST:
            begin
                if (!ph_reg && (ray_h == '0))
                begin
                    dist_next  = DIST_SAT;
                    state_next = S_HGT;
                end
                else if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    dist_next  = delta_sat;
                    ph_next    = 1'b0;
                    state_next = S_HGT;
                end
            end
            S_HGT:
            begin
                if (!ph_reg && (dist_reg == '0))
                begin
                    lh_next    = LINE_SAT;
                    state_next = S_WALL;
                end
                else if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    lh_next    = (div_rsp.quo > DIV_W'(LINE_SAT)) ? LINE_SAT
                               : div_rsp.quo[LH_W-1:0];
                    ph_next    = 1'b0;
                    state_next = S_WALL;
                end
            end
            S_WALL:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                    res_column_next = col_reg;
                    res_dist_next   = dist_reg;
                    res_lh_next     = lh_reg;
                    res_start_next  = ({1'b0, lh_reg} >= SH17) ? 9'd0 : row_diff[9:1];
                    res_end_next    = (row_half > ROW_LAST) ? ROW_LAST[8:0] : row_half[8:0];
                    res_side_next   = hit_i_reg;
                    res_tex_next    = {hit_i_reg, (ray_h[RAY_W-1] || (ray_h == '0))};
                    res_texcol_next = tex_prod[21:16];
                    res_hx_next     = walk_x_reg[5:0];
                    res_hy_next     = walk_y_reg[5:0];
                    res_nowall_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (((state_reg == S_FETCH) && off_map)
            || ((state_reg == S_TEST) && (map_rdata == '0) && (cnt_reg == STEP_LAST)))
        begin
            done_next       = 1'b1;
            res_column_next = col_reg;
            res_dist_next   = '0;
            res_lh_next     = '0;
            res_start_next  = '0;
            res_end_next    = '0;
            res_side_next   = 1'b0;
            res_tex_next    = '0;
            res_texcol_next = '0;
            res_hx_next     = '0;
            res_hy_next     = '0;
            res_nowall_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ax_reg    <= 1'b0;
            ph_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            ph_reg    <= ph_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        camx_reg       <= camx_next;
        ray_x_reg      <= ray_x_next;
        ray_y_reg      <= ray_y_next;
        delta_x_reg    <= delta_x_next;
        delta_y_reg    <= delta_y_next;
        side_x_reg     <= side_x_next;
        side_y_reg     <= side_y_next;
        walk_x_reg     <= walk_x_next;
        walk_y_reg     <= walk_y_next;
        cnt_reg        <= cnt_next;
        hit_i_reg      <= hit_i_next;
        dist_reg       <= dist_next;
        lh_reg         <= lh_next;
        res_column_reg <= res_column_next;
        res_dist_reg   <= res_dist_next;
        res_lh_reg     <= res_lh_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        res_side_reg   <= res_side_next;
        res_tex_reg    <= res_tex_next;
        res_texcol_reg <= res_texcol_next;
        res_hx_reg     <= res_hx_next;
        res_hy_reg     <= res_hy_next;
        res_nowall_reg <= res_nowall_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign out_column     = res_column_reg;
    assign wall_distance  = res_dist_reg;
    assign line_height    = res_lh_reg;
    assign wall_row_start = res_start_reg;
    assign wall_row_end   = res_end_reg;
    assign hit_side       = res_side_reg;
    assign texture_index  = res_tex_reg;
    assign texture_column = res_texcol_reg;
    assign hit_x          = res_hx_reg;
    assign hit_y          = res_hy_reg;
    assign no_wall        = res_nowall_reg;

    `DCR_ASSERT_IMP(a_done_after_cast, done, $past(busy), "result strobe without a cast in flight")
    `DCR_ASSERT_NXT(a_cast_goes_busy, start && !busy && kind, busy, "cast request not taken")
    `DCR_ASSERT_IMP(a_div_idle_on_go, div_req.go, !div_rsp.busy, "divider restarted mid-division")
    `DCR_ASSERT_IMP(a_nowall_clean, done && no_wall, (wall_distance == '0) && (line_height == '0) && (hit_side == 1'b0), "miss result carries hit data")

endmodule

// ===== tb/sv/dcr_checker.sv =====
`timescale 1ns / 100ps

module dcr_checker
    import dcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        kind,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [7:0]  cell_value,
    input  logic [9:0]  column,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_data,
    input  logic        done,
    input  logic [9:0]  out_column,
    input  logic [30:0] wall_distance,
    input  logic [15:0] line_height,
    input  logic [8:0]  wall_row_start,
    input  logic [8:0]  wall_row_end,
    input  logic        hit_side,
    input  logic [1:0]  texture_index,
    input  logic [5:0]  texture_column,
    input  logic [5:0]  hit_x,
    input  logic [5:0]  hit_y,
    input  logic        no_wall,
    output int          errors,
    output int          pending,
    output int          casts_seen,
    output int          open_rays
);

    localparam longint SCR_W = 640;
    localparam longint SCR_H = 480;
    localparam longint GRID  = 64;
    localparam longint ONE   = 65536;
    localparam longint DSAT  = 64'h7FFF_FFFF;
    localparam longint LSAT  = 65535;

    typedef struct packed {
        logic [9:0]  column;
        logic [30:0] wdist;
        logic [15:0] lh;
        logic [8:0]  row_start;
        logic [8:0]  row_end;
        logic        side;
        logic [1:0]  tex;
        logic [5:0]  tex_col;
        logic [5:0]  hx;
        logic [5:0]  hy;
        logic        missed;
    } column_result_t;

    logic [7:0]         cells [4096];
    logic [22:0]        cam_px, cam_py;
    logic signed [18:0] cam_dx, cam_dy, cam_plx, cam_ply;
    column_result_t     column_q [$];

    function automatic longint floor16(input longint v);
        if (v >= 0)
            return v >>> 16;
        return -((-v + 65535) >>> 16);
    endfunction

    function automatic longint magn(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic column_result_t cast_column(input logic [9:0] col);
        longint p[2], r[2], dl[2], sd[2], c[2], st[2];
        longint camx, pdist, lh, rs, re, num, wl, fr;
        int ax, n;
        bit hit;
        column_result_t res;
        res = '0;
        res.column = col;
        ax = 0;
        hit = 0;
        camx = (2 * longint'(col) * ONE) / SCR_W - ONE;
        p[0] = longint'(cam_px);
        p[1] = longint'(cam_py);
        r[0] = longint'(cam_dx) + floor16(longint'(cam_plx) * camx);
        r[1] = longint'(cam_dy) + floor16(longint'(cam_ply) * camx);
        for (int a = 0; a < 2; a++)
        begin
            if (r[a] == 0)
                dl[a] = DSAT;
            else
            begin
                dl[a] = (64'sd1 << 32) / magn(r[a]);
                if (dl[a] > DSAT)
                    dl[a] = DSAT;
            end
            st[a] = (r[a] < 0) ? -1 : 1;
            c[a] = p[a] >>> 16;
            fr = p[a] & 16'hFFFF;
            if (st[a] > 0)
                sd[a] = ((ONE - fr) * dl[a]) >>> 16;
            else
                sd[a] = (fr * dl[a]) >>> 16;
        end
        for (n = 0; n < 2 * GRID + 2; n++)
        begin
            ax = (sd[0] < sd[1]) ? 0 : 1;
            sd[ax] += dl[ax];
            c[ax] += st[ax];
            if (c[0] < 0 || c[0] >= GRID || c[1] < 0 || c[1] >= GRID)
                break;
            if (cells[c[1] * GRID + c[0]] != 0)
            begin
                hit = 1;
                break;
            end
        end
        if (!hit)
        begin
            res.missed = 1'b1;
            return res;
        end
        num = c[ax] * ONE - p[ax] + ((st[ax] < 0) ? ONE : 0);
        if (r[ax] == 0)
            pdist = DSAT;
        else
        begin
            pdist = (magn(num) * ONE) / magn(r[ax]);
            if (pdist > DSAT)
                pdist = DSAT;
        end
        if (pdist == 0)
            lh = LSAT;
        else
        begin
            lh = (SCR_H * ONE) / pdist;
            if (lh > LSAT)
                lh = LSAT;
        end
        rs = (SCR_H - lh) / 2;
        if (rs < 0)
            rs = 0;
        re = (SCR_H + lh) / 2;
        if (re > SCR_H - 1)
            re = SCR_H - 1;
        wl = p[1 - ax] + floor16(pdist * r[1 - ax]);
        fr = wl & 16'hFFFF;
        res.wdist = pdist[30:0];
        res.lh = lh[15:0];
        res.row_start = rs[8:0];
        res.row_end = re[8:0];
        res.side = ax[0];
        res.tex = 2'(ax * 2 + ((r[ax] > 0) ? 0 : 1));
        res.tex_col = 6'((fr * 64) >>> 16);
        res.hx = c[0][5:0];
        res.hy = c[1][5:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        casts_seen = 0;
        open_rays = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        column_result_t want;
        if (!rst_n)
        begin
            cam_px  <= 23'd98304;
            cam_py  <= 23'd98304;
            cam_dx  <= 19'sd65536;
            cam_dy  <= 19'sd0;
            cam_plx <= 19'sd0;
            cam_ply <= 19'sd43254;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POS_X:   cam_px  <= cfg_data;
                    REG_POS_Y:   cam_py  <= cfg_data;
                    REG_DIR_X:   cam_dx  <= cfg_data[18:0];
                    REG_DIR_Y:   cam_dy  <= cfg_data[18:0];
                    REG_PLANE_X: cam_plx <= cfg_data[18:0];
                    REG_PLANE_Y: cam_ply <= cfg_data[18:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (column_q.size() == 0)
                    report_mismatch("unexpected result, column", out_column, -1);
                else
                begin
                    want = column_q.pop_front();
                    if (out_column != want.column)
                        report_mismatch("out_column", out_column, want.column);
                    if (wall_distance != want.wdist)
                        report_mismatch("wall_distance", wall_distance, want.wdist);
                    if (line_height != want.lh)
                        report_mismatch("line_height", line_height, want.lh);
                    if (wall_row_start != want.row_start)
                        report_mismatch("wall_row_start", wall_row_start, want.row_start);
                    if (wall_row_end != want.row_end)
                        report_mismatch("wall_row_end", wall_row_end, want.row_end);
                    if (hit_side != want.side)
                        report_mismatch("hit_side", hit_side, want.side);
                    if (texture_index != want.tex)
                        report_mismatch("texture_index", texture_index, want.tex);
                    if (texture_column != want.tex_col)
                        report_mismatch("texture_column", texture_column, want.tex_col);
                    if (hit_x != want.hx)
                        report_mismatch("hit_x", hit_x, want.hx);
                    if (hit_y != want.hy)
                        report_mismatch("hit_y", hit_y, want.hy);
                    if (no_wall != want.missed)
                        report_mismatch("no_wall", no_wall, want.missed);
                end
            end
            if (start && !busy)
            begin
                if (kind)
                begin
                    want = cast_column(column);
                    column_q.push_back(want);
                    casts_seen++;
                    if (want.missed)
                        open_rays++;
                end
                else
                    cells[{cell_y, cell_x}] = cell_value;
            end
            pending = column_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import dcr_pkg::*;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int         QMAX        = 131072;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        kind = 1'b0;
    logic [5:0]  cell_x = '0;
    logic [5:0]  cell_y = '0;
    logic [7:0]  cell_value = '0;
    logic [9:0]  column = '0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [22:0] cfg_data = '0;
    logic        done;
    logic [9:0]  out_column;
    logic [30:0] wall_distance;
    logic [15:0] line_height;
    logic [8:0]  wall_row_start;
    logic [8:0]  wall_row_end;
    logic        hit_side;
    logic [1:0]  texture_index;
    logic [5:0]  texture_column;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic        no_wall;
    int          errors, pending, casts_seen, open_rays;
    bit          quiet = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dda_column_raycaster DUT (.*);

    dcr_checker u_checker (.*);

    task automatic issue(input logic k, input int cx, input int cy, input int val,
                         input int col);
        int gap;
        if (!quiet && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(19, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        cell_x <= 6'(cx);
        cell_y <= 6'(cy);
        cell_value <= 8'(val);
        column <= 10'(col);
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic put_cell(input int cx, input int cy, input int val);
        issue(1'b0, cx, cy, val, $urandom_range(1023));
    endtask

    task automatic cast(input int col);
        issue(1'b1, $urandom_range(63), $urandom_range(63), $urandom_range(255), col);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (500) @(posedge clk);
    endtask

    task automatic program_camera(input int px, input int py, input int dx, input int dy,
                                  input int plx, input int ply);
        cfg_we <= 1'b1;
        cfg_index <= REG_POS_X;   cfg_data <= 23'(px);  @(posedge clk);
        cfg_index <= REG_POS_Y;   cfg_data <= 23'(py);  @(posedge clk);
        cfg_index <= REG_DIR_X;   cfg_data <= 23'(dx);  @(posedge clk);
        cfg_index <= REG_DIR_Y;   cfg_data <= 23'(dy);  @(posedge clk);
        cfg_index <= REG_PLANE_X; cfg_data <= 23'(plx); @(posedge clk);
        cfg_index <= REG_PLANE_Y; cfg_data <= 23'(ply); @(posedge clk);
        cfg_index <= REG_SPARE_A; cfg_data <= 23'($urandom); @(posedge clk);
        cfg_index <= REG_SPARE_B; cfg_data <= 23'($urandom); @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_q16();
        case ($urandom_range(5))
            0: return -QMAX;
            1: return QMAX;
            2: return 0;
            default: return int'($urandom_range(2 * QMAX)) - QMAX;
        endcase
    endfunction

    function automatic int pick_column();
        case ($urandom_range(7))
            0: return 0;
            1: return 639;
            2: return 320;
            default: return $urandom_range(1023);
        endcase
    endfunction

    // The camera sits inside a walled box, so every walk stays on written cells.
    task automatic box_phase(input int n_casts);
        int w, h, bx, by, cx, cy, v;
        w = $urandom_range(10, 3);
        h = $urandom_range(10, 3);
        bx = $urandom_range(64 - w);
        by = $urandom_range(64 - h);
        cx = $urandom_range(bx + w - 2, bx + 1);
        cy = $urandom_range(by + h - 2, by + 1);
        drain();
        program_camera((cx << 16) | $urandom_range(65535), (cy << 16) | $urandom_range(65535),
                       pick_q16(), pick_q16(), pick_q16(), pick_q16());
        for (int y = by; y < by + h; y++)
            for (int x = bx; x < bx + w; x++)
            begin
                if (x == bx || y == by || x == bx + w - 1 || y == by + h - 1)
                    v = $urandom_range(255, 1);
                else
                    v = ($urandom_range(6) == 0) ? $urandom_range(255, 1) : 0;
                put_cell(x, y, v);
            end
        repeat (n_casts) cast(pick_column());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default view inside a tight box, with corners of the map and edge columns.
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                put_cell(x, y, (x == 1 && y == 1) ? 0 : ((x + y) % 2 ? 255 : 1));
        put_cell(63, 63, 8'hAA);
        put_cell(63, 0, 8'h55);
        put_cell(0, 63, 8'h80);
        cast(0);
        cast(1);
        cast(319);
        cast(320);
        cast(639);
        cast(640);
        cast(1023);

        // Ray starts on an empty first row and leaves the map through the top edge or a side.
        drain();
        program_camera((($urandom_range(1) ? 0 : $urandom_range(63)) << 16)
                       | $urandom_range(65535),
                       $urandom_range(65535), pick_q16(),
                       -int'($urandom_range(QMAX, 1000)), pick_q16(), 0);
        for (int x = 0; x < 64; x++)
            put_cell(x, 0, 0);
        repeat (12) cast(pick_column());

        // Camera outside the map on both axes.
        drain();
        program_camera(4194304, 4194304, pick_q16(), pick_q16(), pick_q16(), pick_q16());
        repeat (6) cast(pick_column());

        for (int ph = 0; ph < 6; ph++)
        begin
            quiet = (ph >= 4);
            box_phase($urandom_range(20, 10));
        end

        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (500) @(posedge clk);
        $display("Cast %0d columns, %0d of them left the map without a wall.",
                 casts_seen, open_rays);
        if (errors == 0)
            $display("dda_column_raycaster verification clean");
        else
            $display("dda_column_raycaster verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("dda_column_raycaster verification failed");
        $finish;
    end

endmodule
